>>> rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants of the cosine top-k vector store: sizes, field
// widths, status and action codes, and the command word of the hit list.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int MAX_LENGTH  = 64;
  localparam int MAX_HITS    = 16;

  // Fixed field widths.
  localparam int ELEM_W    = 16;
  localparam int KEY_W     = 32;
  localparam int SIZE_W    = 48;
  localparam int TIME_W    = 40;
  localparam int SCORE_W   = 16;
  localparam int RANK_W    = 4;
  localparam int STATUS_W  = 3;
  localparam int ACTION_W  = 2;
  localparam int LEN_CFG_W = 7;
  localparam int LIM_W     = 5;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 7;
  localparam int FRAC      = 14;

  // Derived widths.
  localparam int SLOT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SCAN_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CNT_RAW = $clog2(MAX_LENGTH + 2);
  localparam int CNT_W   = (CNT_RAW > LEN_CFG_W) ? CNT_RAW : LEN_CFG_W;
  localparam int ELEM_AW = (MAX_ENTRIES * MAX_LENGTH > 1) ?
                           $clog2(MAX_ENTRIES * MAX_LENGTH) : 1;
  localparam int HIT_W   = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int HCNT_W  = $clog2(MAX_HITS + 1);
  localparam int DOT_W   = 2 * ELEM_W + IDX_W;
  localparam int NORM_W  = 2 * ELEM_W - 1 + IDX_W;
  localparam int PROD_W  = 2 * NORM_W;
  localparam int SHIFT   = 2 * FRAC;
  localparam int QW      = SHIFT + 1;
  localparam int ROOT_W  = FRAC + 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_HIT      = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_REJECTED = 3'd6
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_LIMIT  = 4'd1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] fsize;
    logic [TIME_W-1:0] mtime;
  } meta_t;

  typedef struct packed {
    logic                      clear;
    logic                      insert;
    logic signed [SCORE_W-1:0] score;
    logic [SLOT_W-1:0]         slot;
  } topk_cmd_t;

endpackage

>>> rtl/cosine_topk_vector_store_unit.sv
// ----------------------------------------------------------------------------
// cosine_topk_vector_store_unit
// Keyed store of fixed-point vectors with brute-force cosine top-k search.
// Elements are staged one word per cycle when idle; add and remove scan the key
// memory, a query scores every valid slot and reports the best hits in order.
// ----------------------------------------------------------------------------
// A non-final element gives no result; a length error answers on the next
// cycle. The time of remove and add is set by the one-port key scan, and for
// add also by the element copy. Query: an empty slot is skipped, a valid slot
// takes the element read plus the serial multiply, divide and root, then the
// hits follow one by one. Results cannot be held off. Reset clears the valid
// bits at once, no sweep.
module cosine_topk_vector_store_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [cts_pkg::ACTION_W-1:0]         action_i,
  input  logic [cts_pkg::KEY_W-1:0]            key_i,
  input  logic signed [cts_pkg::ELEM_W-1:0]    element_value_i,
  input  logic                                 last_element_i,
  input  logic [cts_pkg::SIZE_W-1:0]           file_size_i,
  input  logic [cts_pkg::TIME_W-1:0]           modified_time_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cts_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cts_pkg::CFG_DAT_W-1:0]        cfg_data_i,
  output logic                                 result_valid_o,
  output logic [cts_pkg::STATUS_W-1:0]         status_o,
  output logic [cts_pkg::KEY_W-1:0]            hit_key_o,
  output logic signed [cts_pkg::SCORE_W-1:0]   score_o,
  output logic [cts_pkg::SIZE_W-1:0]           hit_size_o,
  output logic [cts_pkg::TIME_W-1:0]           hit_modified_time_o,
  output logic [cts_pkg::RANK_W-1:0]           rank_o,
  output logic                                 last_result_o
);

  localparam int NE  = cts_pkg::MAX_ENTRIES;
  localparam int NL  = cts_pkg::MAX_LENGTH;
  localparam int SLW = cts_pkg::SLOT_W;
  localparam int SCW = cts_pkg::SCAN_W;
  localparam int IXW = cts_pkg::IDX_W;
  localparam int CTW = cts_pkg::CNT_W;
  localparam int EAW = cts_pkg::ELEM_AW;
  localparam int EW  = cts_pkg::ELEM_W;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_SCAN     = 11'b00000000010,
    S_DECIDE   = 11'b00000000100,
    S_COPY     = 11'b00000001000,
    S_QSLOT    = 11'b00000010000,
    S_QACC     = 11'b00000100000,
    S_QSTART   = 11'b00001000000,
    S_QWAIT    = 11'b00010000000,
    S_QEND     = 11'b00100000000,
    S_OUT_RD   = 11'b01000000000,
    S_OUT_EMIT = 11'b10000000000
  } state_e;

  typedef struct packed {
    cts_pkg::status_e                    status;
    logic [cts_pkg::KEY_W-1:0]           key;
    logic signed [cts_pkg::SCORE_W-1:0]  score;
    logic [cts_pkg::SIZE_W-1:0]          fsize;
    logic [cts_pkg::TIME_W-1:0]          mtime;
    logic [cts_pkg::RANK_W-1:0]          rank;
    logic                                last;
  } res_t;

  // Configuration.
  logic [cts_pkg::LEN_CFG_W-1:0] vlen_q;
  logic [cts_pkg::LIM_W-1:0]     limit_q;

  // Control and datapath registers.
  state_e                      state_q, state_d;
  logic [CTW-1:0]              stage_cnt_q, stage_cnt_d;
  logic [cts_pkg::NORM_W-1:0]  na_acc_q, na_acc_d, na_q, na_d;
  cts_pkg::action_e            op_q, op_d;
  logic [cts_pkg::KEY_W-1:0]   key_q, key_d;
  logic [cts_pkg::SIZE_W-1:0]  size_q, size_d;
  logic [cts_pkg::TIME_W-1:0]  time_q, time_d;
  logic [CTW-1:0]              len_q, len_d;
  logic [SCW-1:0]              scan_q, scan_d;
  logic                        chk_vld_q, chk_vld_d;
  logic [SLW-1:0]              chk_slot_q, chk_slot_d;
  logic                        match_q, match_d;
  logic [SLW-1:0]              match_slot_q, match_slot_d;
  logic [cts_pkg::SIZE_W-1:0]  match_size_q, match_size_d;
  logic [cts_pkg::TIME_W-1:0]  match_time_q, match_time_d;
  logic                        free_q, free_d;
  logic [SLW-1:0]              free_slot_q, free_slot_d;
  logic [SLW-1:0]              tgt_slot_q, tgt_slot_d;
  cts_pkg::status_e            add_status_q, add_status_d;
  logic [CTW-1:0]              idx_q, idx_d;
  logic                        pipe_vld_q, pipe_vld_d;
  logic [IXW-1:0]              pipe_idx_q, pipe_idx_d;
  logic [SCW-1:0]              qslot_q, qslot_d;
  logic signed [cts_pkg::DOT_W-1:0] dot_q, dot_d;
  logic [cts_pkg::NORM_W-1:0]  nb_q, nb_d;
  logic [cts_pkg::HIT_W-1:0]   rank_q, rank_d;
  logic [cts_pkg::HCNT_W-1:0]  n_q, n_d;
  logic                        res_vld_q, res_vld_d;
  res_t                        res_q, res_d;
  logic [NE-1:0]               slot_valid_q;
  logic                        valid_set, valid_clr;

  // Memories.
  logic signed [EW-1:0] stage_mem [NL];
  logic signed [EW-1:0] elem_mem  [NE*NL];
  cts_pkg::meta_t       meta_mem  [NE];
  logic                 stage_we;
  logic [IXW-1:0]       stage_raddr;
  logic signed [EW-1:0] stage_rd_q;
  logic                 elem_we;
  logic [EAW-1:0]       elem_waddr, elem_raddr;
  logic signed [EW-1:0] elem_rd_q;
  logic                 meta_we;
  logic [SLW-1:0]       meta_raddr;
  cts_pkg::meta_t       meta_rd_q;

  // Arithmetic and helpers.
  logic signed [2*EW-1:0]     in_sq, qs_prod, ss_prod;
  logic [cts_pkg::NORM_W-1:0] na_step;
  logic [CTW-1:0]             cnt_inc;
  logic                       len_ok;
  logic                       accept;
  logic [cts_pkg::HCNT_W-1:0] lim_eff;

  // Units.
  cts_pkg::topk_cmd_t                 topk_cmd;
  logic signed [cts_pkg::SCORE_W-1:0] topk_score;
  logic [SLW-1:0]                     topk_slot;
  logic [cts_pkg::HCNT_W-1:0]         topk_fill;
  logic                               cos_start, cos_done;
  logic signed [cts_pkg::SCORE_W-1:0] cos_score;

  cts_cosine u_cosine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cos_start),
    .dot_i   (dot_q),
    .na_i    (na_q),
    .nb_i    (nb_q),
    .done_o  (cos_done),
    .score_o (cos_score)
  );

  cts_topk u_topk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (topk_cmd),
    .rd_rank_i  (rank_q),
    .rd_score_o (topk_score),
    .rd_slot_o  (topk_slot),
    .fill_o     (topk_fill)
  );

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign in_sq   = element_value_i * element_value_i;
  assign qs_prod = stage_rd_q * elem_rd_q;
  assign ss_prod = elem_rd_q * elem_rd_q;
  assign na_step = (stage_cnt_q < CTW'(NL)) ?
                   na_acc_q + cts_pkg::NORM_W'($unsigned(in_sq)) : na_acc_q;
  assign cnt_inc = (stage_cnt_q <= CTW'(NL)) ? stage_cnt_q + 1'b1 : stage_cnt_q;
  assign len_ok  = (cnt_inc <= CTW'(NL)) && (cnt_inc == CTW'(vlen_q));

  always_comb begin
    if (limit_q == '0) begin
      lim_eff = cts_pkg::HCNT_W'(1);
    end else if (int'(limit_q) > cts_pkg::MAX_HITS) begin
      lim_eff = cts_pkg::HCNT_W'(cts_pkg::MAX_HITS);
    end else begin
      lim_eff = cts_pkg::HCNT_W'(limit_q);
    end
  end

  always_comb begin
    state_d      = state_q;
    stage_cnt_d  = stage_cnt_q;
    na_acc_d     = na_acc_q;
    na_d         = na_q;
    op_d         = op_q;
    key_d        = key_q;
    size_d       = size_q;
    time_d       = time_q;
    len_d        = len_q;
    scan_d       = scan_q;
    chk_vld_d    = chk_vld_q;
    chk_slot_d   = chk_slot_q;
    match_d      = match_q;
    match_slot_d = match_slot_q;
    match_size_d = match_size_q;
    match_time_d = match_time_q;
    free_d       = free_q;
    free_slot_d  = free_slot_q;
    tgt_slot_d   = tgt_slot_q;
    add_status_d = add_status_q;
    idx_d        = idx_q;
    pipe_vld_d   = 1'b0;
    pipe_idx_d   = pipe_idx_q;
    qslot_d      = qslot_q;
    dot_d        = dot_q;
    nb_d         = nb_q;
    rank_d       = rank_q;
    n_d          = n_q;
    res_vld_d    = 1'b0;
    res_d        = '0;
    valid_set    = 1'b0;
    valid_clr    = 1'b0;
    stage_we     = 1'b0;
    stage_raddr  = idx_q[IXW-1:0];
    elem_we      = 1'b0;
    elem_waddr   = EAW'(tgt_slot_q) * EAW'(NL) + EAW'(pipe_idx_q);
    elem_raddr   = EAW'(qslot_q[SLW-1:0]) * EAW'(NL) + EAW'(idx_q[IXW-1:0]);
    meta_we      = 1'b0;
    meta_raddr   = topk_slot;
    topk_cmd     = '0;
    topk_cmd.score = cos_score;
    topk_cmd.slot  = qslot_q[SLW-1:0];
    cos_start    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_i)
            cts_pkg::ACT_REMOVE: begin
              op_d      = cts_pkg::ACT_REMOVE;
              key_d     = key_i;
              scan_d    = '0;
              chk_vld_d = 1'b0;
              match_d   = 1'b0;
              free_d    = 1'b0;
              state_d   = S_SCAN;
            end
            cts_pkg::ACT_ADD, cts_pkg::ACT_QUERY: begin
              stage_we = (stage_cnt_q < CTW'(NL));
              if (!last_element_i) begin
                stage_cnt_d = cnt_inc;
                na_acc_d    = na_step;
              end else begin
                stage_cnt_d = '0;
                na_acc_d    = '0;
                na_d        = na_step;
                len_d       = cnt_inc;
                key_d       = key_i;
                size_d      = file_size_i;
                time_d      = modified_time_i;
                if (!len_ok) begin
                  res_vld_d    = 1'b1;
                  res_d.status = cts_pkg::ST_REJECTED;
                  res_d.key    = (action_i == cts_pkg::ACT_ADD) ? key_i : '0;
                  res_d.last   = 1'b1;
                end else if (action_i == cts_pkg::ACT_ADD) begin
                  op_d      = cts_pkg::ACT_ADD;
                  scan_d    = '0;
                  chk_vld_d = 1'b0;
                  match_d   = 1'b0;
                  free_d    = 1'b0;
                  state_d   = S_SCAN;
                end else begin
                  op_d           = cts_pkg::ACT_QUERY;
                  topk_cmd.clear = 1'b1;
                  qslot_d        = '0;
                  state_d        = S_QSLOT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // Read the key memory one slot a cycle; compare in the cycle after the read.
        meta_raddr = scan_q[SLW-1:0];
        chk_vld_d  = (scan_q < SCW'(NE));
        chk_slot_d = scan_q[SLW-1:0];
        if (scan_q < SCW'(NE)) scan_d = scan_q + 1'b1;
        if (chk_vld_q) begin
          if (slot_valid_q[chk_slot_q]) begin
            if (!match_q && meta_rd_q.key == key_q) begin
              match_d      = 1'b1;
              match_slot_d = chk_slot_q;
              match_size_d = meta_rd_q.fsize;
              match_time_d = meta_rd_q.mtime;
            end
          end else if (!free_q) begin
            free_d      = 1'b1;
            free_slot_d = chk_slot_q;
          end
        end
        if (scan_q == SCW'(NE)) state_d = S_DECIDE;
      end

      S_DECIDE: begin
        state_d = S_IDLE;
        if (op_q == cts_pkg::ACT_REMOVE) begin
          res_vld_d = 1'b1;
          res_d.key = key_q;
          res_d.last = 1'b1;
          if (match_q) begin
            valid_clr    = 1'b1;
            res_d.status = cts_pkg::ST_REMOVED;
            res_d.fsize  = match_size_q;
            res_d.mtime  = match_time_q;
          end else begin
            res_d.status = cts_pkg::ST_ABSENT;
          end
        end else if (match_q || free_q) begin
          tgt_slot_d   = match_q ? match_slot_q : free_slot_q;
          add_status_d = match_q ? cts_pkg::ST_UPDATED : cts_pkg::ST_ADDED;
          idx_d        = '0;
          state_d      = S_COPY;
        end else begin
          res_vld_d    = 1'b1;
          res_d.status = cts_pkg::ST_REJECTED;
          res_d.key    = key_q;
          res_d.last   = 1'b1;
        end
      end

      S_COPY: begin
        pipe_vld_d = (idx_q < len_q);
        pipe_idx_d = idx_q[IXW-1:0];
        if (idx_q < len_q) idx_d = idx_q + 1'b1;
        elem_we = pipe_vld_q;
        if (idx_q == len_q) begin
          meta_we      = 1'b1;
          valid_set    = 1'b1;
          res_vld_d    = 1'b1;
          res_d.status = add_status_q;
          res_d.key    = key_q;
          res_d.fsize  = size_q;
          res_d.mtime  = time_q;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_QSLOT: begin
        if (qslot_q == SCW'(NE)) begin
          state_d = S_QEND;
        end else if (slot_valid_q[qslot_q[SLW-1:0]]) begin
          idx_d   = '0;
          dot_d   = '0;
          nb_d    = '0;
          state_d = S_QACC;
        end else begin
          qslot_d = qslot_q + 1'b1;
        end
      end

      S_QACC: begin
        pipe_vld_d = (idx_q < len_q);
        if (idx_q < len_q) idx_d = idx_q + 1'b1;
        if (pipe_vld_q) begin
          dot_d = dot_q + cts_pkg::DOT_W'(qs_prod);
          nb_d  = nb_q + cts_pkg::NORM_W'($unsigned(ss_prod));
        end
        if (idx_q == len_q) state_d = S_QSTART;
      end

      S_QSTART: begin
        cos_start = 1'b1;
        state_d   = S_QWAIT;
      end

      S_QWAIT: begin
        if (cos_done) begin
          topk_cmd.insert = 1'b1;
          qslot_d         = qslot_q + 1'b1;
          state_d         = S_QSLOT;
        end
      end

      S_QEND: begin
        if (topk_fill == '0) begin
          res_vld_d    = 1'b1;
          res_d.status = cts_pkg::ST_EMPTY;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          n_d     = (topk_fill < lim_eff) ? topk_fill : lim_eff;
          rank_d  = '0;
          state_d = S_OUT_RD;
        end
      end

      S_OUT_RD: begin
        state_d = S_OUT_EMIT;
      end

      S_OUT_EMIT: begin
        res_vld_d    = 1'b1;
        res_d.status = cts_pkg::ST_HIT;
        res_d.key    = meta_rd_q.key;
        res_d.score  = topk_score;
        res_d.fsize  = meta_rd_q.fsize;
        res_d.mtime  = meta_rd_q.mtime;
        res_d.rank   = cts_pkg::RANK_W'(rank_q);
        res_d.last   = (cts_pkg::HCNT_W'(rank_q) + 1'b1 == n_q);
        if (res_d.last) begin
          state_d = S_IDLE;
        end else begin
          rank_d  = rank_q + 1'b1;
          state_d = S_OUT_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q       <= cts_pkg::LEN_CFG_W'(64);
      limit_q      <= cts_pkg::LIM_W'(8);
      state_q      <= S_IDLE;
      stage_cnt_q  <= '0;
      na_acc_q     <= '0;
      slot_valid_q <= '0;
      scan_q       <= '0;
      chk_vld_q    <= 1'b0;
      match_q      <= 1'b0;
      free_q       <= 1'b0;
      idx_q        <= '0;
      pipe_vld_q   <= 1'b0;
      qslot_q      <= '0;
      rank_q       <= '0;
      n_q          <= '0;
      res_vld_q    <= 1'b0;
      op_q         <= cts_pkg::ACT_NONE;
      add_status_q <= cts_pkg::ST_ADDED;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          cts_pkg::CFG_VECTOR_LENGTH: vlen_q  <= cfg_data_i;
          cts_pkg::CFG_RESULT_LIMIT:  limit_q <= cfg_data_i[cts_pkg::LIM_W-1:0];
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      stage_cnt_q <= stage_cnt_d;
      na_acc_q    <= na_acc_d;
      if (valid_clr) slot_valid_q[match_slot_q] <= 1'b0;
      if (valid_set) slot_valid_q[tgt_slot_q] <= 1'b1;
      scan_q       <= scan_d;
      chk_vld_q    <= chk_vld_d;
      match_q      <= match_d;
      free_q       <= free_d;
      idx_q        <= idx_d;
      pipe_vld_q   <= pipe_vld_d;
      qslot_q      <= qslot_d;
      rank_q       <= rank_d;
      n_q          <= n_d;
      res_vld_q    <= res_vld_d;
      op_q         <= op_d;
      add_status_q <= add_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    na_q         <= na_d;
    key_q        <= key_d;
    size_q       <= size_d;
    time_q       <= time_d;
    len_q        <= len_d;
    chk_slot_q   <= chk_slot_d;
    match_slot_q <= match_slot_d;
    match_size_q <= match_size_d;
    match_time_q <= match_time_d;
    free_slot_q  <= free_slot_d;
    tgt_slot_q   <= tgt_slot_d;
    pipe_idx_q   <= pipe_idx_d;
    dot_q        <= dot_d;
    nb_q         <= nb_d;
    res_q        <= res_d;
  end

  // Staging buffer: written at intake, read during copy and scoring.
  always_ff @(posedge clk_i) begin
    if (stage_we) stage_mem[stage_cnt_q[IXW-1:0]] <= element_value_i;
    stage_rd_q <= stage_mem[stage_raddr];
  end

  // Element memory, one row of MAX_LENGTH words per slot.
  always_ff @(posedge clk_i) begin
    if (elem_we) elem_mem[elem_waddr] <= stage_rd_q;
    elem_rd_q <= elem_mem[elem_raddr];
  end

  // Key and metadata memory.
  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[tgt_slot_q] <= '{key: key_q, fsize: size_q, mtime: time_q};
    meta_rd_q <= meta_mem[meta_raddr];
  end

  assign result_valid_o      = res_vld_q;
  assign status_o            = res_q.status;
  assign hit_key_o           = res_q.key;
  assign score_o             = res_q.score;
  assign hit_size_o          = res_q.fsize;
  assign hit_modified_time_o = res_q.mtime;
  assign rank_o              = res_q.rank;
  assign last_result_o       = res_q.last;

  // The block is busy exactly while more results of the item are due.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (busy == !last_result_o))
    else $error("busy does not match the pending result sequence");

  // Anything but a hit is a single result with rank zero and no score.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != cts_pkg::ST_HIT) |->
      (last_result_o && rank_o == '0 && score_o == '0))
    else $error("non-hit result carries hit fields");

  // Hits follow with a read state between them, in rising rank and non-rising score.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == cts_pkg::ST_HIT && !last_result_o) |-> ##2
      (result_valid_o && status_o == cts_pkg::ST_HIT &&
       rank_o == $past(rank_o, 2) + 1'b1 && score_o <= $past(score_o, 2)))
    else $error("hit sequence out of order");

endmodule

>>> rtl/cts_cosine.sv
// ----------------------------------------------------------------------------
// cts_cosine
// Multi-cycle cosine scorer: squares the dot product and multiplies the two
// norms by shift-and-add, divides bit-serially, then takes an integer square
// root one bit per cycle. Result is signed Q1.14.
// ----------------------------------------------------------------------------
module cts_cosine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [cts_pkg::DOT_W-1:0]   dot_i,
  input  logic [cts_pkg::NORM_W-1:0]         na_i,
  input  logic [cts_pkg::NORM_W-1:0]         nb_i,
  output logic                               done_o,
  output logic signed [cts_pkg::SCORE_W-1:0] score_o
);

  localparam int NW = cts_pkg::NORM_W;
  localparam int PW = cts_pkg::PROD_W;
  localparam int QW = cts_pkg::QW;
  localparam int RW = cts_pkg::ROOT_W;
  localparam int SW = cts_pkg::SCORE_W;
  localparam int CW = $clog2(((NW > QW) ? NW : QW) + 1);

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_MUL  = 5'b00010,
    C_DIV  = 5'b00100,
    C_SQRT = 5'b01000,
    C_DONE = 5'b10000
  } cos_state_e;

  cos_state_e state_q, state_d;
  logic          neg_q, neg_d;
  logic [NW-1:0] mpa_q, mpa_d, mpb_q, mpb_d;
  logic [PW-1:0] mca_q, mca_d, mcb_q, mcb_d;
  logic [PW-1:0] dsq_q, dsq_d, p_q, p_d;
  logic [PW:0]   rem_q, rem_d;
  logic [QW-1:0] dbits_q, dbits_d, quo_q, quo_d;
  logic [RW-1:0] root_q, root_d, mask_q, mask_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic signed [SW-1:0] score_q, score_d;

  logic [cts_pkg::DOT_W-1:0] dot_abs;
  logic [PW:0]               rem_sh;
  logic [RW-1:0]             trial;
  logic [2*RW-1:0]           trial_sq;

  assign dot_abs  = dot_i[cts_pkg::DOT_W-1] ? -dot_i : dot_i;
  assign rem_sh   = {rem_q[PW-1:0], dbits_q[QW-1]};
  assign trial    = root_q | mask_q;
  assign trial_sq = trial * trial;

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    mpa_d   = mpa_q;
    mpb_d   = mpb_q;
    mca_d   = mca_q;
    mcb_d   = mcb_q;
    dsq_d   = dsq_q;
    p_d     = p_q;
    rem_d   = rem_q;
    dbits_d = dbits_q;
    quo_d   = quo_q;
    root_d  = root_q;
    mask_d  = mask_q;
    cnt_d   = cnt_q;
    score_d = score_q;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          if (na_i == '0 || nb_i == '0) begin
            score_d = '0;
            state_d = C_DONE;
          end else begin
            neg_d   = dot_i[cts_pkg::DOT_W-1];
            mpa_d   = dot_abs[NW-1:0];
            mca_d   = PW'(dot_abs[NW-1:0]);
            mpb_d   = na_i;
            mcb_d   = PW'(nb_i);
            dsq_d   = '0;
            p_d     = '0;
            cnt_d   = CW'(NW);
            state_d = C_MUL;
          end
        end
      end
      C_MUL: begin
        if (cnt_q == '0) begin
          // The squared dot never exceeds the norm product, so the quotient
          // fits in QW bits and the first partial remainder is below p.
          rem_d   = {1'b0, dsq_q >> 1};
          dbits_d = {dsq_q[0], {cts_pkg::SHIFT{1'b0}}};
          quo_d   = '0;
          cnt_d   = CW'(QW);
          state_d = C_DIV;
        end else begin
          if (mpa_q[0]) dsq_d = dsq_q + mca_q;
          if (mpb_q[0]) p_d = p_q + mcb_q;
          mpa_d = mpa_q >> 1;
          mpb_d = mpb_q >> 1;
          mca_d = mca_q << 1;
          mcb_d = mcb_q << 1;
          cnt_d = cnt_q - 1'b1;
        end
      end
      C_DIV: begin
        if (cnt_q == '0) begin
          root_d  = '0;
          mask_d  = RW'(1) << (RW - 1);
          state_d = C_SQRT;
        end else begin
          if (rem_sh >= {1'b0, p_q}) begin
            rem_d = rem_sh - {1'b0, p_q};
            quo_d = {quo_q[QW-2:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            quo_d = {quo_q[QW-2:0], 1'b0};
          end
          dbits_d = dbits_q << 1;
          cnt_d   = cnt_q - 1'b1;
        end
      end
      C_SQRT: begin
        if (mask_q == '0) begin
          score_d = neg_q ? -SW'(root_q) : SW'(root_q);
          state_d = C_DONE;
        end else begin
          if (trial_sq <= (2*RW)'(quo_q)) root_d = trial;
          mask_d = mask_q >> 1;
        end
      end
      C_DONE: begin
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    mpa_q   <= mpa_d;
    mpb_q   <= mpb_d;
    mca_q   <= mca_d;
    mcb_q   <= mcb_d;
    dsq_q   <= dsq_d;
    p_q     <= p_d;
    rem_q   <= rem_d;
    dbits_q <= dbits_d;
    quo_q   <= quo_d;
    root_q  <= root_d;
    mask_q  <= mask_d;
    score_q <= score_d;
  end

  assign done_o  = (state_q == C_DONE);
  assign score_o = score_q;

endmodule

>>> rtl/cts_topk.sv
// ----------------------------------------------------------------------------
// cts_topk
// Sorted list of the best scores seen in a search, best first. Slots arrive
// in ascending order, so a new score goes behind every equal score.
// ----------------------------------------------------------------------------
module cts_topk (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cts_pkg::topk_cmd_t                 cmd_i,
  input  logic [cts_pkg::HIT_W-1:0]          rd_rank_i,
  output logic signed [cts_pkg::SCORE_W-1:0] rd_score_o,
  output logic [cts_pkg::SLOT_W-1:0]         rd_slot_o,
  output logic [cts_pkg::HCNT_W-1:0]         fill_o
);

  localparam int N = cts_pkg::MAX_HITS;

  logic signed [cts_pkg::SCORE_W-1:0] score_q [N];
  logic signed [cts_pkg::SCORE_W-1:0] score_d [N];
  logic [cts_pkg::SLOT_W-1:0]         slot_q  [N];
  logic [cts_pkg::SLOT_W-1:0]         slot_d  [N];
  logic [cts_pkg::HCNT_W-1:0]         fill_q, fill_d;
  logic [N-1:0]                       ahead;

  // An entry stays ahead of the newcomer when it is filled and not worse.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ahead[i] = (cts_pkg::HCNT_W'(i) < fill_q) && (score_q[i] >= cmd_i.score);
    end
  end

  always_comb begin
    score_d[0] = ahead[0] ? score_q[0] : cmd_i.score;
    slot_d[0]  = ahead[0] ? slot_q[0]  : cmd_i.slot;
    for (int i = 1; i < N; i++) begin
      if (ahead[i]) begin
        score_d[i] = score_q[i];
        slot_d[i]  = slot_q[i];
      end else if (ahead[i-1]) begin
        score_d[i] = cmd_i.score;
        slot_d[i]  = cmd_i.slot;
      end else begin
        score_d[i] = score_q[i-1];
        slot_d[i]  = slot_q[i-1];
      end
    end
    fill_d = fill_q;
    if (cmd_i.clear) begin
      fill_d = '0;
    end else if (cmd_i.insert && fill_q != cts_pkg::HCNT_W'(N)) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      for (int i = 0; i < N; i++) begin
        score_q[i] <= score_d[i];
        slot_q[i]  <= slot_d[i];
      end
    end
  end

  assign rd_score_o = score_q[rd_rank_i];
  assign rd_slot_o  = slot_q[rd_rank_i];
  assign fill_o     = fill_q;

endmodule
